### hw/rtl/bloom_filter_double_hash_macros.svh
// assertion macros for the bloom filter block
// used by the datapath and the top level; no other dependencies
`ifndef BLOOM_FILTER_DOUBLE_HASH_MACROS_SVH
`define BLOOM_FILTER_DOUBLE_HASH_MACROS_SVH

// same-cycle implication, disabled in reset
`define BFDH_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define BFDH_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/bfdh_pkg.sv
// shared types, constants and the microcode table of the bloom filter block
// no dependencies; every other rtl file but the macros header imports it
`timescale 1ns / 1ps

package bfdh_pkg;

  localparam int KEY_W     = 32;
  localparam int DATA_W    = 32;
  localparam int IDX_W     = 10;
  localparam int OP_W      = 2;
  localparam int PROBE_W   = 5;
  localparam int WORDS_W   = 11;
  localparam int BIT_W     = 5;
  localparam int POS_W     = WORDS_W + BIT_W;
  localparam int STEP_W    = 4;
  localparam int CFG_W     = 11;
  localparam int MAX_PROBES = 30;
  localparam int DELTA_ROT = 17;

  // remainder unit: 28-bit dividend, four quotient bits a cycle
  localparam int DIV_N     = 28;
  localparam int DIV_BITS  = 4;
  localparam int DIV_STEPS = DIV_N / DIV_BITS;
  localparam int DIV_CNT_W = 3;

  // 2^32 / 32, so that 2^32 mod (w*32) = (2^27 mod w) * 32
  localparam logic [DIV_N-1:0] WRAP_DIVIDEND = {1'b1, {(DIV_N-1){1'b0}}};

  typedef logic [OP_W-1:0] op_t;
  localparam op_t OP_ADD   = 2'd0;
  localparam op_t OP_QUERY = 2'd1;
  localparam op_t OP_LOAD  = 2'd2;

  typedef logic [0:0] cfg_index_t;
  localparam cfg_index_t CFG_PROBE_COUNT  = 1'd0;
  localparam cfg_index_t CFG_WORDS_IN_USE = 1'd1;

  localparam logic [PROBE_W-1:0] RESET_PROBES = 5'd7;
  localparam logic [WORDS_W-1:0] RESET_WORDS  = 11'd1024;

  typedef struct packed {
    logic [PROBE_W-1:0] probe_count;
    logic [WORDS_W-1:0] words_in_use;
  } cfg_t;

  typedef struct packed {
    logic clr_more;
    logic is_key;
    logic div_busy;
    logic probe_more;
  } dp_status_t;

  typedef logic [1:0] div_sel_t;
  localparam div_sel_t DIV_HASH  = 2'd0;
  localparam div_sel_t DIV_DELTA = 2'd1;
  localparam div_sel_t DIV_WRAP  = 2'd2;

  typedef logic [2:0] mem_op_t;
  localparam mem_op_t MEM_NONE  = 3'd0;
  localparam mem_op_t MEM_CLEAR = 3'd1;
  localparam mem_op_t MEM_READ  = 3'd2;
  localparam mem_op_t MEM_PROBE = 3'd3;
  localparam mem_op_t MEM_LOAD  = 3'd4;

  typedef logic [1:0] stall_t;
  localparam stall_t STALL_NONE     = 2'd0;
  localparam stall_t STALL_NO_INPUT = 2'd1;
  localparam stall_t STALL_DIV_BUSY = 2'd2;
  localparam stall_t STALL_OUT_BUSY = 2'd3;

  typedef logic [2:0] jump_t;
  localparam jump_t JMP_NEVER      = 3'd0;
  localparam jump_t JMP_ALWAYS     = 3'd1;
  localparam jump_t JMP_CLR_MORE   = 3'd2;
  localparam jump_t JMP_NOT_KEY    = 3'd3;
  localparam jump_t JMP_PROBE_MORE = 3'd4;

  typedef logic [STEP_W-1:0] step_t;
  localparam step_t ST_CLEAR     = 4'd0;
  localparam step_t ST_IDLE      = 4'd1;
  localparam step_t ST_DISPATCH  = 4'd2;
  localparam step_t ST_DIV_H     = 4'd3;
  localparam step_t ST_WAIT_H    = 4'd4;
  localparam step_t ST_DIV_D     = 4'd5;
  localparam step_t ST_WAIT_D    = 4'd6;
  localparam step_t ST_DIV_C     = 4'd7;
  localparam step_t ST_WAIT_C    = 4'd8;
  localparam step_t ST_PROBE_RD  = 4'd9;
  localparam step_t ST_PROBE_UPD = 4'd10;
  localparam step_t ST_FINISH    = 4'd11;
  localparam step_t ST_LOAD      = 4'd12;

  typedef struct packed {
    logic     in_take;
    logic     div_start;
    logic     div_latch;
    div_sel_t div_sel;
    mem_op_t  mem_op;
    logic     out_load;
    stall_t   stall;
    jump_t    jump;
    step_t    target;
  } ctl_word_t;

  // control store: a stall holds the step, otherwise a taken jump goes to
  // target and anything else falls through to the next step
  function automatic ctl_word_t ucode(input step_t step);
    ctl_word_t cw;
    cw = '0;
    unique case (step)
      ST_CLEAR: begin
        cw.mem_op = MEM_CLEAR;
        cw.jump   = JMP_CLR_MORE;
        cw.target = ST_CLEAR;
      end
      ST_IDLE: begin
        cw.in_take = 1'b1;
        cw.stall   = STALL_NO_INPUT;
      end
      ST_DISPATCH: begin
        cw.jump   = JMP_NOT_KEY;
        cw.target = ST_LOAD;
      end
      ST_DIV_H: begin
        cw.div_start = 1'b1;
        cw.div_sel   = DIV_HASH;
      end
      ST_WAIT_H: begin
        cw.div_latch = 1'b1;
        cw.div_sel   = DIV_HASH;
        cw.stall     = STALL_DIV_BUSY;
      end
      ST_DIV_D: begin
        cw.div_start = 1'b1;
        cw.div_sel   = DIV_DELTA;
      end
      ST_WAIT_D: begin
        cw.div_latch = 1'b1;
        cw.div_sel   = DIV_DELTA;
        cw.stall     = STALL_DIV_BUSY;
      end
      ST_DIV_C: begin
        cw.div_start = 1'b1;
        cw.div_sel   = DIV_WRAP;
      end
      ST_WAIT_C: begin
        cw.div_latch = 1'b1;
        cw.div_sel   = DIV_WRAP;
        cw.stall     = STALL_DIV_BUSY;
      end
      ST_PROBE_RD: begin
        cw.mem_op = MEM_READ;
      end
      ST_PROBE_UPD: begin
        cw.mem_op = MEM_PROBE;
        cw.jump   = JMP_PROBE_MORE;
        cw.target = ST_PROBE_RD;
      end
      ST_FINISH: begin
        cw.out_load = 1'b1;
        cw.stall    = STALL_OUT_BUSY;
        cw.jump     = JMP_ALWAYS;
        cw.target   = ST_IDLE;
      end
      ST_LOAD: begin
        cw.mem_op = MEM_LOAD;
        cw.jump   = JMP_ALWAYS;
        cw.target = ST_FINISH;
      end
      default: begin
        cw.jump   = JMP_ALWAYS;
        cw.target = ST_IDLE;
      end
    endcase
    return cw;
  endfunction

endpackage

### hw/rtl/bfdh_in_if.sv
// request channel of the bloom filter block: valid, ready and the item fields
// depends on bfdh_pkg
`timescale 1ns / 1ps

interface bfdh_in_if import bfdh_pkg::*; ();
  logic              valid;
  logic              ready;
  op_t               operation;
  logic [KEY_W-1:0]  key_hash;
  logic [IDX_W-1:0]  word_index;
  logic [DATA_W-1:0] word_data;

  modport source (output valid, operation, key_hash, word_index, word_data, input ready);
  modport sink   (input valid, operation, key_hash, word_index, word_data, output ready);
endinterface

### hw/rtl/bfdh_out_if.sv
// response channel of the bloom filter block: valid, ready and the result bit
// depends on bfdh_pkg
`timescale 1ns / 1ps

interface bfdh_out_if import bfdh_pkg::*; ();
  logic valid;
  logic ready;
  logic may_contain;

  modport source (output valid, may_contain, input ready);
  modport sink   (input valid, may_contain, output ready);
endinterface

### hw/rtl/bfdh_divider.sv
// iterative remainder unit: 28-bit dividend by 11-bit divisor, 4 bits a cycle
// depends on bfdh_pkg
`timescale 1ns / 1ps

module bfdh_divider import bfdh_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [DIV_N-1:0]   dividend,
  input  logic [WORDS_W-1:0] divisor,
  output logic               busy,
  output logic [WORDS_W-1:0] remainder
);

  logic [DIV_N-1:0]   num;
  logic [DIV_N-1:0]   num_next;
  logic [WORDS_W-1:0] rem;
  logic [WORDS_W-1:0] rem_next;
  logic [WORDS_W:0]   trial;
  logic [DIV_CNT_W-1:0] cnt;

  // restoring steps; the partial remainder stays below the divisor
  always_comb begin
    rem_next = rem;
    num_next = num;
    trial    = '0;
    for (int i = 0; i < DIV_BITS; i++) begin
      trial    = {rem_next, num_next[DIV_N-1]};
      num_next = {num_next[DIV_N-2:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
        rem_next = WORDS_W'(trial - {1'b0, divisor});
      end else begin
        rem_next = trial[WORDS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + DIV_CNT_W'(1);
      if (cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num <= dividend;
      rem <= '0;
    end else if (busy) begin
      num <= num_next;
      rem <= rem_next;
    end
  end

  assign remainder = rem;

endmodule

### hw/rtl/bfdh_datapath.sv
// datapath of the bloom filter block: item registers, probe arithmetic,
// bit store and its clearing pass; depends on bfdh_pkg, bfdh_divider, macros
`timescale 1ns / 1ps
`include "bloom_filter_double_hash_macros.svh"

module bfdh_datapath import bfdh_pkg::*; #(
  parameter int FILTER_WORDS = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  ctl_word_t         ctl,
  input  cfg_t              cfg,
  input  logic              take,
  input  op_t               operation,
  input  logic [KEY_W-1:0]  key_hash,
  input  logic [IDX_W-1:0]  word_index,
  input  logic [DATA_W-1:0] word_data,
  output dp_status_t        status,
  output logic              result
);

  localparam int AW = (FILTER_WORDS > 1) ? $clog2(FILTER_WORDS) : 1;

  logic [DATA_W-1:0] mem [FILTER_WORDS];

  op_t                op;
  logic [KEY_W-1:0]   h;
  logic [KEY_W-1:0]   delta;
  logic [IDX_W-1:0]   idx;
  logic [DATA_W-1:0]  load_data;
  logic [PROBE_W-1:0] k;
  logic [WORDS_W-1:0] w;
  logic [POS_W-1:0]   pos;
  logic [POS_W-1:0]   dmod;
  logic [POS_W-1:0]   cmod;
  logic [PROBE_W-1:0] cnt;
  logic               all_set;
  logic [AW-1:0]      clr_addr;
  logic [DATA_W-1:0]  rd_data;

  logic [PROBE_W-1:0] k_act;
  logic [WORDS_W-1:0] w_act;
  logic [POS_W-1:0]   total;
  logic [DIV_N-1:0]   dividend;
  logic               div_busy;
  logic [WORDS_W-1:0] div_rem;
  logic [KEY_W:0]     hsum;
  logic [POS_W:0]     psum;
  logic [POS_W-1:0]   pos_wrapped;
  logic [POS_W-1:0]   pos_next;
  logic [AW-1:0]      pos_addr;
  logic [DATA_W-1:0]  bit_mask;
  logic               idx_ok;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [DATA_W-1:0]  wr_data;

  // register values out of range are clamped when an item is taken
  always_comb begin
    if (cfg.probe_count == '0) begin
      k_act = PROBE_W'(1);
    end else if (32'(cfg.probe_count) > MAX_PROBES) begin
      k_act = PROBE_W'(MAX_PROBES);
    end else begin
      k_act = cfg.probe_count;
    end
    if (cfg.words_in_use == '0) begin
      w_act = WORDS_W'(1);
    end else if (32'(cfg.words_in_use) > FILTER_WORDS) begin
      w_act = WORDS_W'(FILTER_WORDS);
    end else begin
      w_act = cfg.words_in_use;
    end
  end

  assign total = {w, {BIT_W{1'b0}}};

  always_comb begin
    unique case (ctl.div_sel)
      DIV_HASH:  dividend = {1'b0, h[KEY_W-1:BIT_W]};
      DIV_DELTA: dividend = {1'b0, delta[KEY_W-1:BIT_W]};
      DIV_WRAP:  dividend = WRAP_DIVIDEND;
      default:   dividend = '0;
    endcase
  end

  bfdh_divider u_divider (
    .clk       (clk),
    .rst       (rst),
    .start     (ctl.div_start),
    .dividend  (dividend),
    .divisor   (w),
    .busy      (div_busy),
    .remainder (div_rem)
  );

  // next probe position: add delta mod total, then take off 2^32 mod total
  // when the 32-bit hash wraps
  always_comb begin
    hsum = {1'b0, h} + {1'b0, delta};
    psum = {1'b0, pos} + {1'b0, dmod};
    if (psum >= {1'b0, total}) begin
      pos_wrapped = POS_W'(psum - {1'b0, total});
    end else begin
      pos_wrapped = psum[POS_W-1:0];
    end
    if (!hsum[KEY_W]) begin
      pos_next = pos_wrapped;
    end else if (pos_wrapped < cmod) begin
      pos_next = pos_wrapped + total - cmod;
    end else begin
      pos_next = pos_wrapped - cmod;
    end
  end

  assign pos_addr = AW'(pos[POS_W-1:BIT_W]);
  assign bit_mask = DATA_W'(1) << pos[BIT_W-1:0];
  assign idx_ok   = 32'(idx) < FILTER_WORDS;

  always_ff @(posedge clk) begin
    if (take) begin
      op        <= operation;
      h         <= key_hash;
      delta     <= {key_hash[DELTA_ROT-1:0], key_hash[KEY_W-1:DELTA_ROT]};
      idx       <= word_index;
      load_data <= word_data;
      k         <= k_act;
      w         <= w_act;
      cnt       <= '0;
      all_set   <= 1'b1;
    end
    if (ctl.div_latch && !div_busy) begin
      unique case (ctl.div_sel)
        DIV_HASH:  pos  <= {div_rem, h[BIT_W-1:0]};
        DIV_DELTA: dmod <= {div_rem, delta[BIT_W-1:0]};
        DIV_WRAP:  cmod <= {div_rem, {BIT_W{1'b0}}};
        default: ;
      endcase
    end
    if (ctl.mem_op == MEM_PROBE) begin
      if (op == OP_QUERY && !rd_data[pos[BIT_W-1:0]]) begin
        all_set <= 1'b0;
      end
      pos <= pos_next;
      h   <= hsum[KEY_W-1:0];
      cnt <= cnt + PROBE_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (ctl.mem_op == MEM_CLEAR) begin
      clr_addr <= clr_addr + AW'(1);
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pos_addr;
    wr_data = rd_data | bit_mask;
    unique case (ctl.mem_op)
      MEM_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_addr;
        wr_data = '0;
      end
      MEM_PROBE: begin
        wr_en = (op == OP_ADD);
      end
      MEM_LOAD: begin
        wr_en   = (op == OP_LOAD) && idx_ok;
        wr_addr = AW'(idx);
        wr_data = load_data;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.mem_op == MEM_READ) begin
      rd_data <= mem[pos_addr];
    end
  end

  assign status.clr_more   = (clr_addr != AW'(FILTER_WORDS - 1));
  assign status.is_key     = (op == OP_ADD) || (op == OP_QUERY);
  assign status.div_busy   = div_busy;
  assign status.probe_more = (cnt != k - PROBE_W'(1));
  assign result            = (op == OP_QUERY) && all_set;

  `BFDH_ASSERT_SAME(a_query_no_write, clk, rst, (ctl.mem_op == MEM_PROBE) && (op == OP_QUERY), !wr_en, "store written during a query probe")
  `BFDH_ASSERT_NEXT(a_first_pos_in_range, clk, rst, ctl.div_latch && !div_busy && (ctl.div_sel == DIV_HASH), pos < total, "first probe position outside filter")
  `BFDH_ASSERT_NEXT(a_next_pos_in_range, clk, rst, ctl.mem_op == MEM_PROBE, pos < total, "advanced probe position outside filter")
  `BFDH_ASSERT_NEXT(a_miss_clears_result, clk, rst, (ctl.mem_op == MEM_PROBE) && (op == OP_QUERY) && !rd_data[pos[BIT_W-1:0]], !all_set, "query miss not recorded")

endmodule

### hw/rtl/bfdh_sequencer.sv
// microcode sequencer: step counter, control store lookup, stalls and jumps
// depends on bfdh_pkg
`timescale 1ns / 1ps

module bfdh_sequencer import bfdh_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       out_busy,
  input  dp_status_t status,
  output ctl_word_t  ctl
);

  step_t upc;
  step_t upc_next;
  logic  stall_now;
  logic  jump_now;

  assign ctl = ucode(upc);

  always_comb begin
    unique case (ctl.stall)
      STALL_NONE:     stall_now = 1'b0;
      STALL_NO_INPUT: stall_now = !in_valid;
      STALL_DIV_BUSY: stall_now = status.div_busy;
      STALL_OUT_BUSY: stall_now = out_busy;
      default:        stall_now = 1'b0;
    endcase
    unique case (ctl.jump)
      JMP_NEVER:      jump_now = 1'b0;
      JMP_ALWAYS:     jump_now = 1'b1;
      JMP_CLR_MORE:   jump_now = status.clr_more;
      JMP_NOT_KEY:    jump_now = !status.is_key;
      JMP_PROBE_MORE: jump_now = status.probe_more;
      default:        jump_now = 1'b0;
    endcase
    priority if (stall_now) begin
      upc_next = upc;
    end else if (jump_now) begin
      upc_next = ctl.target;
    end else begin
      upc_next = upc + STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= ST_CLEAR;
    end else begin
      upc <= upc_next;
    end
  end

endmodule

### hw/rtl/bloom_filter_double_hash.sv
// top level of the bloom filter block: configuration registers, handshakes,
// result register; depends on bfdh_pkg, the channel interfaces, sequencer, datapath
//
// request carries one item a transfer: operation (add, query, load word),
// key_hash for add and query, word_index and word_data for load word.
// response carries one may_contain bit for every request, in order; it is 1
// only for a query whose probed bits were all set.
// cfg_we writes cfg_data into register cfg_index (0 probe count, 1 words in
// use) at the clock edge; write only while no item is in flight.
// an add or query runs three remainder runs (hash, delta, wrap) on the
// shared 4-bit-a-cycle divider, then a read and an update step per probe
// (k probes, clamped to 1..30) on the single-port bit store, then loads the
// result register. a load word writes its word when its index is in range,
// then loads the result. the next request is taken only after that load.
// after reset the store is cleared one word a cycle, from the first word to
// the last, with request.ready low; registers return to 7 probes and 1024 words.
// a stalled response holds in its register; the block finishes the next
// item's probes meanwhile and waits at the end until the result is taken.
`timescale 1ns / 1ps
`include "bloom_filter_double_hash_macros.svh"

module bloom_filter_double_hash import bfdh_pkg::*; #(
  parameter int FILTER_WORDS = 1024
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  cfg_index_t       cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  bfdh_in_if.sink          request,
  bfdh_out_if.source       response
);

  cfg_t       cfg;
  ctl_word_t  ctl;
  dp_status_t status;
  logic       take;
  logic       out_busy;
  logic       out_load;
  logic       result;
  logic       out_valid;
  logic       out_bit;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.probe_count  <= RESET_PROBES;
      cfg.words_in_use <= RESET_WORDS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PROBE_COUNT:  cfg.probe_count  <= cfg_data[PROBE_W-1:0];
        CFG_WORDS_IN_USE: cfg.words_in_use <= cfg_data[WORDS_W-1:0];
        default: ;
      endcase
    end
  end

  assign request.ready = ctl.in_take;
  assign take          = request.valid && ctl.in_take;
  assign out_busy      = out_valid && !response.ready;
  assign out_load      = ctl.out_load && !out_busy;

  bfdh_sequencer u_sequencer (
    .clk      (clk),
    .rst      (rst),
    .in_valid (request.valid),
    .out_busy (out_busy),
    .status   (status),
    .ctl      (ctl)
  );

  bfdh_datapath #(
    .FILTER_WORDS (FILTER_WORDS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .cfg        (cfg),
    .take       (take),
    .operation  (request.operation),
    .key_hash   (request.key_hash),
    .word_index (request.word_index),
    .word_data  (request.word_data),
    .status     (status),
    .result     (result)
  );

  // result register parts the response side from the sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (response.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_bit <= result;
    end
  end

  assign response.valid       = out_valid;
  assign response.may_contain = out_bit;

  `BFDH_ASSERT_NEXT(a_one_item_at_a_time, clk, rst, request.valid && request.ready, !request.ready, "request taken on consecutive cycles")
  `BFDH_ASSERT_NEXT(a_result_presented, clk, rst, out_load, response.valid, "loaded result not presented")

endmodule

### dv/tb_bloom_filter_double_hash.sv
// self-checking testbench for bloom_filter_double_hash: directed and random
// adds, queries and word loads under several filter shapes and idle mixes
// depends on bfdh_pkg, bfdh_in_if, bfdh_out_if and the block itself
`timescale 1ns / 1ps

module tb_bloom_filter_double_hash;
  import bfdh_pkg::*;

  localparam int FILTER_WORDS = 1024;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 120;
  localparam int REPORT_LIMIT = 10;
  localparam int PHASES       = 10;
  localparam int PHASE_ITEMS  = 95;
  localparam int POOL_DEPTH   = 64;
  localparam op_t OP_SPARE    = 2'd3;

  typedef struct {
    op_t               operation;
    logic [KEY_W-1:0]  key_hash;
    logic [IDX_W-1:0]  word_index;
    logic [DATA_W-1:0] word_data;
  } bloom_item_t;

  typedef struct {
    op_t              operation;
    logic [KEY_W-1:0] key_hash;
    logic             may_contain;
  } lookup_answer_t;

  logic             clk;
  logic             rst;
  logic             cfg_we;
  cfg_index_t       cfg_index;
  logic [CFG_W-1:0] cfg_data;

  bfdh_in_if  req_ch ();
  bfdh_out_if rsp_ch ();

  bloom_filter_double_hash #(
    .FILTER_WORDS (FILTER_WORDS)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .request   (req_ch),
    .response  (rsp_ch)
  );

  // shadow of the bit store and the two registers
  logic [DATA_W-1:0]  filter_model [0:FILTER_WORDS-1];
  logic [PROBE_W-1:0] model_probes;
  logic [WORDS_W-1:0] model_words;

  bloom_item_t    requests_to_send [$];
  lookup_answer_t answers_due [$];
  logic [KEY_W-1:0] added_hashes [$];

  int open_items;
  int failures;
  int cycle_count;
  int sender_idle_pct;
  int receiver_stall_pct;

  int phase_probes [PHASES] = '{1, 30, 2, 4, 31, 0, 0, 0, 0, 5};
  int phase_words  [PHASES] = '{1, 1024, 3, 33, 0, 2047, 0, 0, 0, 1000};

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic int active_words();
    if (model_words == 0) return 1;
    if (model_words > FILTER_WORDS) return FILTER_WORDS;
    return int'(model_words);
  endfunction

  // applies one item to the shadow store and returns its may_contain bit
  function automatic logic probe_filter(input bloom_item_t it);
    logic [31:0] h;
    logic [31:0] delta;
    logic [31:0] span;
    logic [31:0] pos;
    int          probes;
    logic        all_set;
    if (it.operation == OP_LOAD) begin
      filter_model[it.word_index] = it.word_data;
      return 1'b0;
    end
    if (it.operation != OP_ADD && it.operation != OP_QUERY) return 1'b0;
    probes = (model_probes == 0) ? 1 :
             (model_probes > MAX_PROBES) ? MAX_PROBES : int'(model_probes);
    span    = 32'(active_words()) << 5;
    h       = it.key_hash;
    delta   = {h[16:0], h[31:17]};
    all_set = 1'b1;
    for (int i = 0; i < probes; i++) begin
      pos = h % span;
      if (it.operation == OP_ADD) begin
        filter_model[pos[14:5]][pos[4:0]] = 1'b1;
      end else if (!filter_model[pos[14:5]][pos[4:0]]) begin
        all_set = 1'b0;
      end
      h = h + delta;
    end
    return (it.operation == OP_QUERY) && all_set;
  endfunction

  function automatic void flag_failure(input string msg);
    failures++;
    if (failures <= REPORT_LIMIT) $display("%s", msg);
  endfunction

  task automatic queue_item(input op_t op, input logic [KEY_W-1:0] hash,
                            input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    bloom_item_t it;
    it.operation  = op;
    it.key_hash   = hash;
    it.word_index = idx;
    it.word_data  = data;
    requests_to_send.push_back(it);
    open_items++;
  endtask

  task automatic wait_idle();
    while (open_items != 0) @(posedge clk);
  endtask

  // one write lands at the edge after the one where the enable goes high
  task automatic write_reg(input cfg_index_t idx, input logic [CFG_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_PROBE_COUNT) model_probes = value[PROBE_W-1:0];
    else model_words = value[WORDS_W-1:0];
  endtask

  task automatic set_filter_shape(input int probes, input int words);
    wait_idle();
    write_reg(CFG_PROBE_COUNT, CFG_W'(probes));
    write_reg(CFG_WORDS_IN_USE, CFG_W'(words));
  endtask

  // request driver
  always @(posedge clk) begin : drive_requests
    bloom_item_t it;
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || req_ch.ready) begin
      if (requests_to_send.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
        it = requests_to_send.pop_front();
        req_ch.valid      <= 1'b1;
        req_ch.operation  <= it.operation;
        req_ch.key_hash   <= it.key_hash;
        req_ch.word_index <= it.word_index;
        req_ch.word_data  <= it.word_data;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) rsp_ch.ready <= 1'b0;
    else rsp_ch.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
  end

  // monitor: predict on each request transfer, check each response transfer
  always @(posedge clk) begin : check_results
    bloom_item_t    it;
    lookup_answer_t answer;
    if (!rst) begin
      if (req_ch.valid && req_ch.ready) begin
        it.operation       = req_ch.operation;
        it.key_hash        = req_ch.key_hash;
        it.word_index      = req_ch.word_index;
        it.word_data       = req_ch.word_data;
        answer.operation   = it.operation;
        answer.key_hash    = it.key_hash;
        answer.may_contain = probe_filter(it);
        answers_due.push_back(answer);
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (answers_due.size() == 0) begin
          flag_failure($sformatf("unexpected response, may_contain %0b", rsp_ch.may_contain));
        end else begin
          answer = answers_due.pop_front();
          open_items--;
          if (rsp_ch.may_contain !== answer.may_contain)
            flag_failure($sformatf("may_contain mismatch op %0d hash %h: expected %0b, got %0b",
                                   answer.operation, answer.key_hash,
                                   answer.may_contain, rsp_ch.may_contain));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_bloom_filter_double_hash failed");
      $finish;
    end
  end

  initial begin
    int               roll;
    int               pick;
    op_t              op;
    logic [KEY_W-1:0] hash;
    logic [IDX_W-1:0] idx;
    logic [DATA_W-1:0] data;

    rst                = 1'b1;
    cfg_we             = 1'b0;
    cfg_index          = CFG_PROBE_COUNT;
    cfg_data           = '0;
    req_ch.valid       = 1'b0;
    req_ch.operation   = OP_ADD;
    req_ch.key_hash    = '0;
    req_ch.word_index  = '0;
    req_ch.word_data   = '0;
    rsp_ch.ready       = 1'b0;
    open_items         = 0;
    failures           = 0;
    cycle_count        = 0;
    sender_idle_pct    = 29;
    receiver_stall_pct = 67;
    model_probes       = RESET_PROBES;
    model_words        = RESET_WORDS;
    for (int w = 0; w < FILTER_WORDS; w++) filter_model[w] = '0;

    phase_probes[6] = $urandom_range(1, 30);
    phase_words[6]  = $urandom_range(1, 64);
    phase_probes[7] = $urandom_range(1, 30);
    phase_words[7]  = $urandom_range(1, 1024);
    phase_probes[8] = $urandom_range(0, 31);
    phase_words[8]  = $urandom_range(0, 2047);

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // reset shape: empty filter, all-zero and all-ones keys, spare opcode,
    // loads at both ends of the store
    queue_item(OP_QUERY, 32'h0, 10'h0, 32'h0);
    queue_item(OP_ADD, 32'h0, 10'h0, 32'h0);
    queue_item(OP_QUERY, 32'h0, 10'h3FF, 32'hFFFF_FFFF);
    queue_item(OP_ADD, 32'hFFFF_FFFF, 10'h3FF, 32'hFFFF_FFFF);
    queue_item(OP_QUERY, 32'hFFFF_FFFF, 10'h0, 32'h0);
    queue_item(OP_QUERY, 32'h1234_5678, 10'h155, 32'h5555_AAAA);
    queue_item(OP_SPARE, 32'hFFFF_FFFF, 10'h3FF, 32'hFFFF_FFFF);
    queue_item(OP_LOAD, 32'hFFFF_FFFF, 10'h3FF, 32'hFFFF_FFFF);
    queue_item(OP_LOAD, 32'h0, 10'h0, 32'h0);
    queue_item(OP_QUERY, 32'h0, 10'h0, 32'h0);

    // zero probes and zero words fall back to one each
    set_filter_shape(0, 0);
    queue_item(OP_ADD, 32'h5, 10'h0, 32'h0);
    queue_item(OP_QUERY, 32'h5, 10'h0, 32'h0);
    queue_item(OP_QUERY, 32'h6, 10'h0, 32'h0);
    queue_item(OP_LOAD, 32'h0, 10'h0, 32'hFFFF_FFFF);
    queue_item(OP_QUERY, 32'hDEAD_BEEF, 10'h0, 32'h0);

    // oversized values saturate at thirty probes and the full store
    set_filter_shape(31, 2047);
    queue_item(OP_ADD, 32'h8000_0000, 10'h200, 32'h0);
    queue_item(OP_QUERY, 32'h8000_0000, 10'h0, 32'h0);
    queue_item(OP_QUERY, 32'h7FFF_FFFF, 10'h0, 32'h0);
    queue_item(OP_ADD, 32'h5A5A_C3C3, 10'h0, 32'h0);
    queue_item(OP_QUERY, 32'h5A5A_C3C3, 10'h0, 32'h0);

    // upper data bits above the probe field are dropped
    set_filter_shape(2046, 1024);
    queue_item(OP_QUERY, 32'h8000_0000, 10'h0, 32'h0);
    queue_item(OP_ADD, 32'hABCD_EF01, 10'h0, 32'h0);
    queue_item(OP_QUERY, 32'hABCD_EF01, 10'h0, 32'h0);

    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase == 3) begin
        sender_idle_pct    = 67;
        receiver_stall_pct = 29;
      end
      if (phase == 6) begin
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
      end
      set_filter_shape(phase_probes[phase], phase_words[phase]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        roll = $urandom_range(0, 99);
        hash = $urandom;
        idx  = IDX_W'($urandom);
        data = $urandom;
        if (roll < 35) begin
          op = OP_ADD;
          if (added_hashes.size() < POOL_DEPTH) added_hashes.push_back(hash);
          else added_hashes[$urandom_range(0, POOL_DEPTH - 1)] = hash;
        end else if (roll < 80) begin
          op   = OP_QUERY;
          pick = $urandom_range(0, 3);
          // one in four a key already added, one in four one bit away, the rest fresh
          if (added_hashes.size() != 0 && pick < 2) begin
            hash = added_hashes[$urandom_range(0, added_hashes.size() - 1)];
            if (pick == 1) hash[$urandom_range(0, KEY_W - 1)] ^= 1'b1;
          end
        end else if (roll < 95) begin
          op = OP_LOAD;
          if ($urandom_range(0, 2) != 0) idx = IDX_W'($urandom_range(0, active_words() - 1));
          pick = $urandom_range(0, 3);
          if (pick == 0) data = '1;
          else if (pick == 1) data = '0;
        end else begin
          op = OP_SPARE;
        end
        queue_item(op, hash, idx, data);
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (answers_due.size() != 0)
      flag_failure($sformatf("%0d responses never arrived", answers_due.size()));
    if (failures == 0) begin
      $display("tb_bloom_filter_double_hash passed");
    end else begin
      $display("tb_bloom_filter_double_hash failed");
    end
    $finish;
  end

endmodule
